### hdl/hrhs_pkg.sv
package hrhs_pkg;

  localparam int CB = 16;
  localparam int DW = CB + 3;
  localparam int QB = CB + 1;
  localparam int NW = DW + QB;

  localparam logic [CB-1:0] ONE = {CB{1'b1}};

  localparam logic [1:0] MODE_TO_HSL = 2'd0;
  localparam logic [1:0] MODE_TO_RGB = 2'd1;
  localparam logic [1:0] MODE_SHIFT  = 2'd2;

  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_HUE  = 1'b1;

  localparam logic [CB+1:0] TURN  = (CB+2)'(1) << CB;
  localparam logic [CB+1:0] THALF = TURN >> 1;
  localparam logic [CB+1:0] T3H   = TURN + THALF;
  localparam logic [CB+1:0] T2    = TURN << 1;
  localparam logic [CB+1:0] T3    = T2 + TURN;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QB-1:0] nb;
    logic [QB-1:0] q;
    logic [DW-1:0] d;
  } div_t;

  typedef struct packed {
    logic [1:0]    mode;
    logic [CB-1:0] offs;
    logic [CB-1:0] c0;
    logic [CB-1:0] c1;
    logic [CB-1:0] c2;
    logic [CB-1:0] h;
    logic [CB-1:0] s;
    logic [CB-1:0] l;
  } side_t;

  // Twice the distance-to-edge weight of one channel, t3 in thirds of a turn.
  function automatic logic [CB:0] hue_x2(input logic [CB+1:0] t3);
    logic [CB+1:0] x;
    if (t3 < THALF) begin
      x = t3;
    end else if (t3 < T3H) begin
      x = THALF;
    end else if (t3 < T2) begin
      x = T2 - t3;
    end else begin
      x = '0;
    end
    return {x[CB-1:0], 1'b0};
  endfunction

  // Floor of n divided by 2^CB - 1, using n = a * 2^CB + b = a * M + a + b.
  function automatic logic [NW-CB:0] div_one(input logic [NW-1:0] n);
    logic [NW-CB-1:0] a;
    logic [NW-CB:0]   s;
    logic [CB:0]      t;
    logic [NW-CB:0]   q;
    a = n[NW-1:CB];
    s = {1'b0, a} + (NW-CB+1)'(n[CB-1:0]);
    t = (CB+1)'(s[NW-CB:CB]) + {1'b0, s[CB-1:0]};
    q = {1'b0, a} + (NW-CB+1)'(s[NW-CB:CB]) + (NW-CB+1)'(t >= {1'b0, ONE});
    return q;
  endfunction

endpackage

### hdl/hrhs_div_cell.sv
module hrhs_div_cell import hrhs_pkg::*; (
  input  logic clk,
  input  div_t din,
  output div_t dout
);

  logic [DW:0] rem_sh;
  logic [DW:0] diff;
  logic        ge;
  div_t        nxt;

  always_comb begin
    rem_sh   = {din.rem, din.nb[QB-1]};
    diff     = rem_sh - {1'b0, din.d};
    ge       = rem_sh >= {1'b0, din.d};
    nxt.rem  = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
    nxt.nb   = {din.nb[QB-2:0], 1'b0};
    nxt.q    = {din.q[QB-2:0], ge};
    nxt.d    = din.d;
  end

  always_ff @(posedge clk) begin
    dout <= nxt;
  end

endmodule

### hdl/hrhs_divider.sv
module hrhs_divider import hrhs_pkg::*; (
  input  logic          clk,
  input  logic [NW-1:0] n,
  input  logic [DW-1:0] d,
  output logic [QB-1:0] q
);

  div_t chain [0:QB];

  assign chain[0] = '{rem: n[NW-1:QB], nb: n[QB-1:0], q: '0, d: d};

  for (genvar i = 0; i < QB; i++) begin : g_cell
    hrhs_div_cell u_cell (
      .clk  (clk),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  assign q = chain[QB].q;

endmodule

### hdl/hsl_rgb_hue_shift.sv
// Pixel color converter between RGB and HSL, one pixel per clock.
// Input: a pixel is taken at a rising edge with start high and busy low.
// busy is high only during reset, so a new pixel may be started every cycle.
// Output: done is high for one cycle with res_first..res_third holding the
// result; results leave in the order the pixels arrived. The receiver has
// no way to stall the block and every result must be taken when shown.
// Throughput: one pixel per cycle, and every mode takes the same path
// through the pipeline. Most of its registers are in the chain of 17
// restoring-division cells for hue and saturation; the RGB half takes
// six more register stages.
// Configuration: cfg_index 0 writes the mode (0 RGB to HSL, 1 HSL to RGB,
// 2 hue shift, 3 pass through), cfg_index 1 writes the hue offset.
// cfg_ready is always high; write only while no pixel is in flight.
// Reset: rst is synchronous; it clears the pipeline, drops results in
// flight, and sets mode and hue offset to zero.
module hsl_rgb_hue_shift import hrhs_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  logic [CB-1:0] comp_first,
  input  logic [CB-1:0] comp_second,
  input  logic [CB-1:0] comp_third,
  output logic          done,
  output logic [CB-1:0] res_first,
  output logic [CB-1:0] res_second,
  output logic [CB-1:0] res_third,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [CB-1:0] cfg_data
);

  localparam int LAT = QB + 8;

  logic [1:0]    mode;
  logic [CB-1:0] hue_offset;

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_TO_HSL;
      hue_offset <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODE: mode       <= cfg_data[1:0];
        CFG_HUE:  hue_offset <= cfg_data;
        default:  mode       <= mode;
      endcase
    end
  end

  // Front stage: extremes, lightness and the dividend and divisor terms.
  logic [CB-1:0] mx, mn, dd;
  logic [CB:0]   sum, den;
  logic [CB-1:0] lv;
  logic [DW-1:0] num, d6;
  logic [CB+1:0] d3;
  logic [DW-1:0] dx2, dx4;
  logic [CB:0]   sum1;
  logic          accept;

  assign accept = start && !busy;

  always_comb begin
    mx = comp_first;
    mn = comp_first;
    if (comp_second > mx) mx = comp_second;
    if (comp_third > mx) mx = comp_third;
    if (comp_second < mn) mn = comp_second;
    if (comp_third < mn) mn = comp_third;
    dd   = mx - mn;
    sum  = {1'b0, mx} + {1'b0, mn};
    sum1 = sum + (CB+1)'(1);
    lv   = sum1[CB:1];
    den  = (sum <= {1'b0, ONE}) ? sum : ({ONE, 1'b0} - sum);
    d3   = {2'b0, dd} + {1'b0, dd, 1'b0};
    d6   = {d3, 1'b0};
    dx2  = DW'({dd, 1'b0});
    dx4  = DW'({dd, 2'b0});
    priority if (mx == comp_first) begin
      if (comp_second >= comp_third) num = DW'(comp_second - comp_third);
      else num = d6 - DW'(comp_third - comp_second);
    end else if (mx == comp_second) begin
      if (comp_third >= comp_first) num = dx2 + DW'(comp_third - comp_first);
      else num = dx2 - DW'(comp_first - comp_third);
    end else begin
      if (comp_first >= comp_second) num = dx4 + DW'(comp_first - comp_second);
      else num = dx4 - DW'(comp_second - comp_first);
    end
  end

  logic          st1_valid;
  side_t         st1_side;
  logic          st1_grey;
  logic [NW-1:0] st1_nh, st1_ns;
  logic [DW-1:0] st1_dh, st1_ds;

  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
    end else begin
      st1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    st1_side <= '{mode: mode, offs: hue_offset, c0: comp_first, c1: comp_second,
                  c2: comp_third, h: '0, s: '0, l: lv};
    st1_grey <= (dd == '0);
    st1_nh   <= NW'({num, {CB{1'b0}}}) + NW'(d3);
    st1_ns   <= NW'({dd, {CB{1'b0}}}) - NW'(dd) + NW'(den[CB:1]);
    st1_dh   <= d6;
    st1_ds   <= DW'(den);
  end

  logic [QB-1:0] q_h, q_s;

  hrhs_divider u_div_h (.clk(clk), .n(st1_nh), .d(st1_dh), .q(q_h));
  hrhs_divider u_div_s (.clk(clk), .n(st1_ns), .d(st1_ds), .q(q_s));

  logic  hs_valid [QB];
  side_t hs_side  [QB];
  logic  hs_grey  [QB];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QB; i++) hs_valid[i] <= 1'b0;
    end else begin
      hs_valid[0] <= st1_valid;
      for (int i = 1; i < QB; i++) hs_valid[i] <= hs_valid[i-1];
    end
  end

  always_ff @(posedge clk) begin
    hs_side[0] <= st1_side;
    hs_grey[0] <= st1_grey;
    for (int i = 1; i < QB; i++) begin
      hs_side[i] <= hs_side[i-1];
      hs_grey[i] <= hs_grey[i-1];
    end
  end

  // HSL result and the HSL operands of the RGB half.
  logic [CB-1:0] h0, s0, hsum;
  side_t         sd_hsl;

  always_comb begin
    h0          = hs_grey[QB-1] ? '0 : q_h[CB-1:0];
    s0          = hs_grey[QB-1] ? '0 : q_s[CB-1:0];
    hsum        = h0 + hs_side[QB-1].offs;
    sd_hsl      = hs_side[QB-1];
    sd_hsl.h    = h0;
    sd_hsl.s    = s0;
  end

  logic          st2_valid;
  side_t         st2_side;
  logic [CB-1:0] st2_h, st2_s, st2_l;

  always_ff @(posedge clk) begin
    if (rst) begin
      st2_valid <= 1'b0;
    end else begin
      st2_valid <= hs_valid[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    st2_side <= sd_hsl;
    if (hs_side[QB-1].mode == MODE_TO_RGB) begin
      st2_h <= hs_side[QB-1].c0;
      st2_s <= hs_side[QB-1].c1;
      st2_l <= hs_side[QB-1].c2;
    end else begin
      st2_h <= hsum;
      st2_s <= s0;
      st2_l <= hs_side[QB-1].l;
    end
  end

  // RGB stage one: l*s product and the hue positions of the channels.
  logic [CB+1:0] h3, tr, tb, tr_raw;

  always_comb begin
    h3     = {2'b0, st2_h} + {1'b0, st2_h, 1'b0};
    tr_raw = h3 + TURN;
    tr     = (tr_raw >= T3) ? (tr_raw - T3) : tr_raw;
    tb     = (h3 >= TURN) ? (h3 - TURN) : (h3 + T2);
  end

  logic            r1_valid, r1_low, r1_sz;
  side_t           r1_side;
  logic [CB-1:0]   r1_l;
  logic [2*CB-1:0] r1_ls, r1_lm, r1_sm;
  logic [CB:0]     r1_xr, r1_xg, r1_xb;

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
    end else begin
      r1_valid <= st2_valid;
    end
  end

  always_ff @(posedge clk) begin
    r1_side <= st2_side;
    r1_l    <= st2_l;
    r1_sz   <= (st2_s == '0);
    r1_low  <= ({st2_l, 1'b0} < {1'b0, ONE});
    r1_ls   <= st2_l * st2_s;
    r1_lm   <= {st2_l, {CB{1'b0}}} - (2*CB)'(st2_l);
    r1_sm   <= {st2_s, {CB{1'b0}}} - (2*CB)'(st2_s);
    r1_xr   <= hue_x2(tr);
    r1_xg   <= hue_x2(h3);
    r1_xb   <= hue_x2(tb);
  end

  // RGB stage two: q and p, both scaled by M.
  logic [2*CB:0] q2w, p2w;

  always_comb begin
    if (r1_low) q2w = {1'b0, r1_lm} + {1'b0, r1_ls};
    else q2w = {1'b0, r1_lm} + {1'b0, r1_sm} - {1'b0, r1_ls};
    p2w = {r1_lm, 1'b0} - q2w;
  end

  logic            r2_valid, r2_sz;
  side_t           r2_side;
  logic [CB-1:0]   r2_l;
  logic [2*CB-1:0] r2_p, r2_dq;
  logic [CB:0]     r2_xr, r2_xg, r2_xb;

  always_ff @(posedge clk) begin
    if (rst) begin
      r2_valid <= 1'b0;
    end else begin
      r2_valid <= r1_valid;
    end
  end

  always_ff @(posedge clk) begin
    r2_side <= r1_side;
    r2_l    <= r1_l;
    r2_sz   <= r1_sz;
    r2_p    <= p2w[2*CB-1:0];
    r2_dq   <= q2w[2*CB-1:0] - p2w[2*CB-1:0];
    r2_xr   <= r1_xr;
    r2_xg   <= r1_xg;
    r2_xb   <= r1_xb;
  end

  // RGB stage three: the ramp products of the three channels.
  logic            r3_valid, r3_sz;
  side_t           r3_side;
  logic [CB-1:0]   r3_l;
  logic [2*CB-1:0] r3_p;
  logic [3*CB:0]   r3_pr, r3_pg, r3_pb;

  always_ff @(posedge clk) begin
    if (rst) begin
      r3_valid <= 1'b0;
    end else begin
      r3_valid <= r2_valid;
    end
  end

  always_ff @(posedge clk) begin
    r3_side <= r2_side;
    r3_l    <= r2_l;
    r3_sz   <= r2_sz;
    r3_p    <= r2_p;
    r3_pr   <= r2_dq * r2_xr;
    r3_pg   <= r2_dq * r2_xg;
    r3_pb   <= r2_dq * r2_xb;
  end

  // RGB stage four: drop the turn scale with rounding offset folded in.
  localparam logic [3*CB+1:0] HALF_MT = (3*CB+2)'(ONE) << (CB - 1);

  logic [3*CB+1:0] ar, ag, ab;

  always_comb begin
    ar = ({1'b0, r3_pr} + HALF_MT) >> CB;
    ag = ({1'b0, r3_pg} + HALF_MT) >> CB;
    ab = ({1'b0, r3_pb} + HALF_MT) >> CB;
  end

  logic          r4_valid, r4_sz;
  side_t         r4_side;
  logic [CB-1:0] r4_l;
  logic [NW-1:0] r4_nr, r4_ng, r4_nb;

  always_ff @(posedge clk) begin
    if (rst) begin
      r4_valid <= 1'b0;
    end else begin
      r4_valid <= r3_valid;
    end
  end

  always_ff @(posedge clk) begin
    r4_side <= r3_side;
    r4_l    <= r3_l;
    r4_sz   <= r3_sz;
    r4_nr   <= NW'(ar) + NW'(r3_p);
    r4_ng   <= NW'(ag) + NW'(r3_p);
    r4_nb   <= NW'(ab) + NW'(r3_p);
  end

  // RGB stage five: divide by M with the folded end-around carry.
  logic           ch_valid, ch_sz;
  side_t          ch_side;
  logic [CB-1:0]  ch_l;
  logic [NW-CB:0] q_r, q_g, q_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_valid <= 1'b0;
    end else begin
      ch_valid <= r4_valid;
    end
  end

  always_ff @(posedge clk) begin
    ch_side <= r4_side;
    ch_sz   <= r4_sz;
    ch_l    <= r4_l;
    q_r     <= div_one(r4_nr);
    q_g     <= div_one(r4_ng);
    q_b     <= div_one(r4_nb);
  end

  // Output select and register.
  logic [CB-1:0] vr, vg, vb;
  logic [CB-1:0] o0, o1, o2;
  side_t         sd_out;

  always_comb begin
    sd_out = ch_side;
    vr = (q_r > (NW-CB+1)'(ONE)) ? ONE : q_r[CB-1:0];
    vg = (q_g > (NW-CB+1)'(ONE)) ? ONE : q_g[CB-1:0];
    vb = (q_b > (NW-CB+1)'(ONE)) ? ONE : q_b[CB-1:0];
    if (ch_sz) begin
      vr = ch_l;
      vg = ch_l;
      vb = ch_l;
    end
    unique case (sd_out.mode)
      MODE_TO_HSL: begin
        o0 = sd_out.h;
        o1 = sd_out.s;
        o2 = sd_out.l;
      end
      MODE_TO_RGB, MODE_SHIFT: begin
        o0 = vr;
        o1 = vg;
        o2 = vb;
      end
      default: begin
        o0 = sd_out.c0;
        o1 = sd_out.c1;
        o2 = sd_out.c2;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ch_valid;
    end
  end

  always_ff @(posedge clk) begin
    res_first  <= o0;
    res_second <= o1;
    res_third  <= o2;
  end

`ifndef SYNTHESIS
  a_done_has_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a matching start transfer");

  a_start_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("start transfer produced no result");
`endif

endmodule
